@@ rtl/fdc_pkg.sv @@
package fdc_pkg;

   localparam int LenWidth   = 16;
   localparam int HuntSpan   = 16;
   localparam int TimerWidth = 16;
   localparam int HuntCntW   = $clog2(HuntSpan + 1);

   localparam logic [15:0] HDR_BYTES      = 16'd29;
   localparam logic [15:0] SMALLEST_FRAME = 16'd33;

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_HEADER  = 3'd1;
   localparam logic [2:0] PH_PAYLOAD = 3'd2;
   localparam logic [2:0] PH_CRC     = 3'd3;

   localparam logic [1:0] REQ_BYTE  = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_VERDICT = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_MAGIC = 2'd1;
   localparam logic [1:0] ERR_LEN   = 2'd2;
   localparam logic [1:0] ERR_CRC   = 2'd3;

   localparam logic [2:0] ADDR_MAGIC  = 3'd0;
   localparam logic [2:0] ADDR_MIN    = 3'd1;
   localparam logic [2:0] ADDR_MAX    = 3'd2;
   localparam logic [2:0] ADDR_WINDOW = 3'd3;
   localparam logic [2:0] ADDR_LIMIT  = 3'd4;

   typedef struct packed {
      logic [15:0] magic_word;
      logic [15:0] min_frame_bytes;
      logic [15:0] max_frame_bytes;
      logic [15:0] error_window_ms;
      logic [3:0]  error_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  payload_byte;
      logic [15:0] msg_type;
      logic [31:0] seq_number;
      logic [63:0] request_id;
      logic [63:0] timestamp_ms;
      logic [1:0]  error_code;
      logic        must_disconnect;
      logic [15:0] discarded_count;
   } rsp_type;

   // error window request from the deframer to the window
   typedef struct packed {
      logic tick;
      logic clear;
      logic err;
   } win_req_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (32'hEDB88320 & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

@@ rtl/fdc_csr.sv @@
module fdc_csr import fdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);
   cfg_type     cfg_ff, cfg_in;
   logic [2:0]  idx;

   assign idx        = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (idx)
            ADDR_MAGIC:  cfg_in.magic_word      = csr_pwdata[15:0];
            ADDR_MIN:    cfg_in.min_frame_bytes = csr_pwdata[15:0];
            ADDR_MAX:    cfg_in.max_frame_bytes = csr_pwdata[15:0];
            ADDR_WINDOW: cfg_in.error_window_ms = csr_pwdata[15:0];
            ADDR_LIMIT:  cfg_in.error_limit     = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         ADDR_MAGIC:  csr_prdata = {16'd0, cfg_ff.magic_word};
         ADDR_MIN:    csr_prdata = {16'd0, cfg_ff.min_frame_bytes};
         ADDR_MAX:    csr_prdata = {16'd0, cfg_ff.max_frame_bytes};
         ADDR_WINDOW: csr_prdata = {16'd0, cfg_ff.error_window_ms};
         ADDR_LIMIT:  csr_prdata = {28'd0, cfg_ff.error_limit};
         default:     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{magic_word: 16'd0, min_frame_bytes: 16'd33,
                     max_frame_bytes: 16'hFFFF, error_window_ms: 16'd10000,
                     error_limit: 4'd3};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

@@ rtl/fdc_window.sv @@
module fdc_window import fdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  win_req_type req,
   output logic        disc
);
   logic [3:0]            errs_ff, errs_in;
   logic [TimerWidth-1:0] age_ff, age_in;
   logic                  valid_ff, valid_in;
   logic                  restart;
   logic [3:0]            errs_base;
   logic [TimerWidth-1:0] age_base;

   assign restart   = !valid_ff || ({16'd0, age_ff} >= {{TimerWidth{1'b0}}, cfg.error_window_ms});
   assign errs_base = restart ? 4'd0 : errs_ff;
   assign age_base  = restart ? '0 : age_ff;
   assign disc = (((errs_base == 4'd15) ? errs_base : errs_base + 4'd1) >= cfg.error_limit)
              && ({16'd0, age_base} < {{TimerWidth{1'b0}}, cfg.error_window_ms});

   always_comb begin
      errs_in  = errs_ff;
      age_in   = age_ff;
      valid_in = valid_ff;
      if (req.clear) begin
         errs_in  = 4'd0;
         age_in   = '0;
         valid_in = 1'b0;
      end else if (req.tick) begin
         if (valid_ff && age_ff != {TimerWidth{1'b1}}) age_in = age_ff + 1'b1;
      end else if (req.err) begin
         errs_in  = (errs_base == 4'd15) ? errs_base : errs_base + 4'd1;
         age_in   = age_base;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         errs_ff  <= 4'd0;
         age_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         errs_ff  <= errs_in;
         age_ff   <= age_in;
         valid_ff <= valid_in;
      end
   end
endmodule

@@ rtl/fdc_core.sv @@
module fdc_core import fdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        go,
   input  logic [1:0]  req_type,
   input  logic [7:0]  rx_byte,
   input  logic        disc,
   output win_req_type win,
   output logic        res_valid,
   output rsp_type     res
);
   logic [2:0]          phase_ff, phase_in;
   logic [7:0]          prev_ff, prev_in;
   logic                pvalid_ff, pvalid_in;
   logic [15:0]         idx_ff, idx_in;
   logic [31:0]         len_ff, len_in;
   logic [15:0]         type_ff, type_in;
   logic [31:0]         seq_ff, seq_in;
   logic [63:0]         reqid_ff, reqid_in;
   logic [63:0]         stamp_ff, stamp_in;
   logic [31:0]         crc_ff, crc_in;
   logic [31:0]         rcrc_ff, rcrc_in;
   logic [HuntCntW-1:0] hunt_ff, hunt_in;
   logic [31:0]         len_new, rcrc_new;
   logic [15:0]         idx_inc, lo;
   logic                len_bad;

   assign idx_inc  = idx_ff + 16'd1;
   assign len_new  = {len_ff[23:0], rx_byte};
   assign rcrc_new = {rcrc_ff[23:0], rx_byte};
   assign lo       = (cfg.min_frame_bytes < SMALLEST_FRAME) ? SMALLEST_FRAME : cfg.min_frame_bytes;
   assign len_bad  = (len_new[31:LenWidth] != '0) || (len_new < {16'd0, lo})
                  || (len_new > {16'd0, cfg.max_frame_bytes});

   always_comb begin
      phase_in = phase_ff; prev_in = prev_ff; pvalid_in = pvalid_ff; idx_in = idx_ff;
      len_in = len_ff; type_in = type_ff; seq_in = seq_ff; reqid_in = reqid_ff;
      stamp_in = stamp_ff; crc_in = crc_ff; rcrc_in = rcrc_ff; hunt_in = hunt_ff;
      win = '0;
      res_valid = 1'b0;
      res = '0;
      if (go && req_type == REQ_TICK) begin
         win.tick = 1'b1;
      end else if (go && req_type == REQ_CLEAR) begin
         win.clear = 1'b1;
         phase_in = PH_HUNT; pvalid_in = 1'b0; prev_in = 8'd0; hunt_in = '0; idx_in = 16'd0;
      end else if (go && req_type == REQ_BYTE) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (pvalid_ff && {prev_ff, rx_byte} == cfg.magic_word) begin
                  crc_in = crc_byte(crc_byte(32'hFFFFFFFF, prev_ff), rx_byte);
                  phase_in = PH_HEADER; idx_in = 16'd2; len_in = '0; type_in = '0;
                  seq_in = '0; reqid_in = '0; stamp_in = '0; rcrc_in = '0;
                  pvalid_in = 1'b0; hunt_in = '0;
                  if (hunt_ff != '0) begin
                     win.err = 1'b1; res_valid = 1'b1;
                     res.out_kind = KIND_ERROR; res.error_code = ERR_MAGIC;
                     res.must_disconnect = disc;
                     res.discarded_count = 16'(hunt_ff);
                  end
               end else begin
                  prev_in = rx_byte; pvalid_in = 1'b1;
                  if (pvalid_ff) begin
                     if (hunt_ff + 1'b1 >= HuntCntW'(HuntSpan)) begin
                        hunt_in = '0;
                        win.err = 1'b1; res_valid = 1'b1;
                        res.out_kind = KIND_ERROR; res.error_code = ERR_MAGIC;
                        res.must_disconnect = disc;
                        res.discarded_count = 16'(hunt_ff + 1'b1);
                     end else begin
                        hunt_in = hunt_ff + 1'b1;
                     end
                  end
               end
            end
            PH_HEADER: begin
               crc_in = crc_byte(crc_ff, rx_byte);
               idx_in = idx_inc;
               if (idx_ff <= 16'd6) begin
                  if (idx_ff >= 16'd3) len_in = len_new;
               end else if (idx_ff <= 16'd8) type_in = {type_ff[7:0], rx_byte};
               else if (idx_ff <= 16'd12) seq_in = {seq_ff[23:0], rx_byte};
               else if (idx_ff <= 16'd20) reqid_in = {reqid_ff[55:0], rx_byte};
               else stamp_in = {stamp_ff[55:0], rx_byte};
               if (idx_inc >= HDR_BYTES)
                  phase_in = (len_ff > {16'd0, SMALLEST_FRAME}) ? PH_PAYLOAD : PH_CRC;
               if (idx_ff == 16'd6 && len_bad) begin
                  win.err = 1'b1; res_valid = 1'b1;
                  res.out_kind = KIND_ERROR; res.error_code = ERR_LEN;
                  res.must_disconnect = 1'b1; res.discarded_count = 16'd7;
                  phase_in = PH_HUNT; pvalid_in = 1'b0; prev_in = 8'd0;
                  hunt_in = '0; idx_in = 16'd0;
               end
            end
            PH_PAYLOAD: begin
               crc_in = crc_byte(crc_ff, rx_byte);
               idx_in = idx_inc;
               if ({16'd0, idx_inc} >= len_ff - 32'd4) phase_in = PH_CRC;
               res_valid = 1'b1;
               res.out_kind = KIND_PAYLOAD; res.payload_byte = rx_byte;
            end
            default: begin
               rcrc_in = rcrc_new;
               idx_in = idx_inc;
               if ({16'd0, idx_inc} >= len_ff) begin
                  res_valid = 1'b1;
                  res.out_kind = KIND_VERDICT;
                  res.msg_type = type_ff; res.seq_number = seq_ff;
                  res.request_id = reqid_ff; res.timestamp_ms = stamp_ff;
                  if (rcrc_new != ~crc_ff) begin
                     win.err = 1'b1;
                     res.error_code = ERR_CRC; res.must_disconnect = disc;
                     res.discarded_count = len_ff[15:0];
                  end
                  phase_in = PH_HUNT; pvalid_in = 1'b0; prev_in = 8'd0;
                  hunt_in = '0; idx_in = 16'd0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT; prev_ff <= '0; pvalid_ff <= 1'b0; idx_ff <= '0;
         len_ff <= '0; type_ff <= '0; seq_ff <= '0; reqid_ff <= '0; stamp_ff <= '0;
         crc_ff <= '1; rcrc_ff <= '0; hunt_ff <= '0;
      end else begin
         phase_ff <= phase_in; prev_ff <= prev_in; pvalid_ff <= pvalid_in; idx_ff <= idx_in;
         len_ff <= len_in; type_ff <= type_in; seq_ff <= seq_in; reqid_ff <= reqid_in;
         stamp_ff <= stamp_in; crc_ff <= crc_in; rcrc_ff <= rcrc_in; hunt_ff <= hunt_in;
      end
   end
endmodule

@@ rtl/frame_deframer_crc32_checker.sv @@
// Magic/length/CRC-32 deframer. One request beat per cycle on req_ (byte, 1 ms tick or clear);
// each beat is processed combinationally from the input register and gives at most one
// rsp_ beat (payload byte, frame verdict or error report). Sustained rate is one beat per
// clock; the output register plus a skid register keep req_tready high while a result waits,
// so only a stalled rsp_ side with both stages full holds the input.
module frame_deframer_crc32_checker import fdc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // rx_byte
   input  logic [1:0]   req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // payload_byte[7:0], msg_type, seq_number, request_id, timestamp_ms,
   // must_disconnect, discarded_count, zero fill to 208 bits
   output logic [207:0] rsp_tdata,
   output logic [3:0]   rsp_tuser,  // out_kind[1:0], error_code[3:2]
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   cfg_type     cfg;
   win_req_type win;
   logic        disc, res_valid;
   rsp_type     res;
   // input register
   logic        iv_ff;
   logic [1:0]  it_ff;
   logic [7:0]  ib_ff;
   // output and skid registers
   logic        ov_ff, sv_ff;
   rsp_type     od_ff, sd_ff;
   logic        go;

   // input stage advances only when the skid has room
   assign req_tready = !sv_ff;
   assign go = iv_ff && !sv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff <= 1'b0;
      end else if (req_tready) begin
         iv_ff <= req_tvalid;
      end
      if (req_tready) begin
         it_ff <= req_tuser;
         ib_ff <= req_tdata;
      end
   end

   fdc_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   fdc_window u_win (.clock, .reset, .cfg, .req(win), .disc);

   fdc_core u_core (
      .clock, .reset, .cfg, .go, .req_type(it_ff), .rx_byte(ib_ff), .disc,
      .win, .res_valid, .res
   );

   // output register with skid: a new result goes to the output if it is free or
   // draining, else parks in the skid
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
         sv_ff <= 1'b0;
      end else begin
         if (!ov_ff || rsp_tready) begin
            if (sv_ff) begin
               ov_ff <= 1'b1;
               od_ff <= sd_ff;
               sv_ff <= 1'b0;
            end else begin
               ov_ff <= go && res_valid;
               od_ff <= res;
            end
         end else if (go && res_valid) begin
            sv_ff <= 1'b1;
            sd_ff <= res;
         end
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {7'd0, od_ff.discarded_count, od_ff.must_disconnect, od_ff.timestamp_ms,
                        od_ff.request_id, od_ff.seq_number, od_ff.msg_type, od_ff.payload_byte};
   assign rsp_tuser  = {od_ff.error_code, od_ff.out_kind};
endmodule

@@ rtl/fdc_checker.sv @@
module fdc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [207:0] rsp_tdata,
   input logic [3:0]   rsp_tuser,
   input logic         csr_pready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |=> req_tready)
      else $error("input stalled though output drains");
   a_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == 2'd0 |-> rsp_tdata[207:8] == '0)
      else $error("payload beat carries header fields");
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3:2] == 2'd2 |-> rsp_tdata[184] && rsp_tuser[1:0] == 2'd2)
      else $error("length error without disconnect");
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind frame_deframer_crc32_checker fdc_checker u_fdc_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tuser, .csr_pready
);
